// File: src/tlvd_pkg.sv
// Shared types and constants of the TLV deframer.
`timescale 1ns / 1ps
package tlvd_pkg;

  // Width of lengths, positions and the buffer size register
  localparam int LEN_W = 21;
  // Bytes skipped at the head of every buffer
  localparam int HEADER_BYTES = 8;
  // Largest buffer honored; larger buffer_length values are clamped to it
  localparam int MAX_BUFFER_BYTES = 1048576;
  // Bits of length carried by one length byte
  localparam int GROUP_BITS = 7;
  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [7:0] MORE_BIT = 8'h80;
  // Largest accumulator that can take one more group without overflow
  localparam logic [LEN_W-1:0] ACC_LIMIT = LEN_W'((1 << (LEN_W - GROUP_BITS)) - 1);

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [7:0]       packet_type;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] packet_length;
    logic             first_of_packet;
    logic             last_of_packet;
  } result_t;

endpackage

// File: src/tlv_varint_packet_deframer_top.sv
// Top level of the TLV deframer with variable-length length field.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one buffer byte per request (data_byte_i, buffer_start_i),
//   taken when in_valid_i is high and in_stall_o is low. buffer_start_i marks
//   byte 0 of a buffer and restarts parsing. After a fixed header, each packet
//   is a type byte, a 7-bit-group length (MSB group first) and its payload.
//   Output channel: one request per payload byte, empty packet or error,
//   taken when out_valid_o is high and out_stall_i is low.
//   APB port: register 0 (address 0) is buffer_length, header included.
//   Throughput: one byte per cycle while in_stall_o is low; the parser is a
//   single registered step; its results enter the registered output stage.
//   Stall: one skid entry backs the output register; in_stall_o rises once
//   a result waits there and falls as soon as the output drains.
//   Reset: buffer_length is 0 and the parser is in the header phase, so bytes
//   before any buffer start produce no results until buffer_length is set.
//   After an error or the buffer end, bytes are dropped until the next start.
module tlv_varint_packet_deframer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input bytes
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       buffer_start_i,
  // Results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 packet_type_o,
  output logic [7:0]                 payload_byte_o,
  output logic [tlvd_pkg::LEN_W-1:0] packet_length_o,
  output logic                       first_of_packet_o,
  output logic                       last_of_packet_o,
  // Configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tlvd_pkg::*;

  localparam logic REG_BUFFER_LENGTH = 1'b0;

  logic [LEN_W-1:0] buffer_length_q;
  logic             accept;
  logic             res_valid;
  result_t          res;
  result_t          out_res;
  logic             skid_full;

  // Write the buffer size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_LENGTH) begin
      buffer_length_q <= pwdata[LEN_W-1:0];
    end
  end

  // Read back the register
  always_comb begin
    if (paddr[2] == REG_BUFFER_LENGTH) begin
      prdata = 32'(buffer_length_q);
    end else begin
      prdata = '0;
    end
  end

  assign pready = 1'b1;

  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  tlvd_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .buffer_start_i (buffer_start_i),
    .buffer_length_i(buffer_length_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  tlvd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  // Spread the result onto its ports
  assign status_o          = out_res.status;
  assign packet_type_o     = out_res.packet_type;
  assign payload_byte_o    = out_res.payload_byte;
  assign packet_length_o   = out_res.packet_length;
  assign first_of_packet_o = out_res.first_of_packet;
  assign last_of_packet_o  = out_res.last_of_packet;

endmodule

// File: src/tlvd_parse.sv
// Byte parser of the TLV deframer: header skip, type, varint length, payload.
`timescale 1ns / 1ps
module tlvd_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     buffer_start_i,
  input  logic [tlvd_pkg::LEN_W-1:0] buffer_length_i,
  output logic                     res_valid_o,
  output tlvd_pkg::result_t        res_o
);
  import tlvd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_STOPPED = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [7:0]       type_q, type_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             first_q, first_d;

  logic [LEN_W-1:0] size_w;
  logic [LEN_W-1:0] pos_cur;
  logic [LEN_W-1:0] acc_new;
  logic [LEN_W-1:0] room_w;
  logic             at_last;
  logic             res_valid;
  result_t          res;

  // Clamp the configured buffer size
  always_comb begin
    if (32'(buffer_length_i) > 32'(MAX_BUFFER_BYTES)) begin
      size_w = LEN_W'(MAX_BUFFER_BYTES);
    end else begin
      size_w = buffer_length_i;
    end
  end

  // Parse one byte and form its result
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    type_d   = type_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    first_d  = first_q;
    res_valid = 1'b0;
    res.status          = ST_DATA;
    res.payload_byte    = '0;
    res.packet_length   = '0;
    res.first_of_packet = 1'b0;
    res.last_of_packet  = 1'b1;

    // Restart on the first byte of a buffer
    if (buffer_start_i) begin
      phase_d = PH_HEADER;
      pos_d   = '0;
      type_d  = '0;
      acc_d   = '0;
      rem_d   = '0;
      first_d = 1'b0;
    end

    pos_cur = pos_d;
    acc_new = {acc_d[LEN_W-GROUP_BITS-1:0], data_byte_i[GROUP_BITS-1:0] & GROUP_MASK[6:0]};
    room_w  = size_w - pos_cur - LEN_W'(1);
    at_last = (pos_cur + LEN_W'(1)) == size_w;

    if (phase_d == PH_STOPPED || pos_cur >= size_w) begin
      // Past the buffer end or after an error: drop the byte
      phase_d = PH_STOPPED;
    end else begin
      pos_d = pos_cur + LEN_W'(1);
      if (phase_d == PH_HEADER && pos_cur >= LEN_W'(HEADER_BYTES)) begin
        phase_d = PH_TYPE;
      end

      unique case (phase_d)
        PH_TYPE: begin
          type_d = data_byte_i;
          acc_d  = '0;
          if (at_last) begin
            res_valid = 1'b1;
            res.status = ST_ERROR;
            phase_d = PH_STOPPED;
          end else begin
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (acc_d > ACC_LIMIT) begin
            // Length no longer fits the register
            res_valid = 1'b1;
            res.status = ST_ERROR;
            res.packet_length = acc_d;
            phase_d = PH_STOPPED;
          end else begin
            acc_d = acc_new;
            if ((data_byte_i & MORE_BIT) != 8'h00) begin
              if (at_last) begin
                res_valid = 1'b1;
                res.status = ST_ERROR;
                res.packet_length = acc_new;
                phase_d = PH_STOPPED;
              end
            end else if (acc_new > room_w) begin
              res_valid = 1'b1;
              res.status = ST_ERROR;
              res.packet_length = acc_new;
              phase_d = PH_STOPPED;
            end else if (acc_new == '0) begin
              res_valid = 1'b1;
              res.status = ST_EMPTY;
              phase_d = PH_TYPE;
            end else begin
              rem_d   = acc_new;
              first_d = 1'b1;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.status = ST_DATA;
          res.payload_byte = data_byte_i;
          res.packet_length = acc_d;
          res.first_of_packet = first_d;
          res.last_of_packet = (rem_d <= LEN_W'(1));
          first_d = 1'b0;
          if (rem_d <= LEN_W'(1)) begin
            rem_d   = '0;
            phase_d = PH_TYPE;
          end else begin
            rem_d = rem_d - LEN_W'(1);
          end
        end
        default: begin
          // Header byte: skip
        end
      endcase
    end

    res.packet_type = type_d;
  end

  // Advance the parse state on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      type_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      first_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      first_q <= first_d;
    end
  end

  assign res_valid_o = accept_i && res_valid;
  assign res_o       = res;

  // A payload result only comes out of the payload phase of a running buffer
  a_data_from_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_DATA) |-> (phase_q == PH_PAYLOAD && !buffer_start_i))
    else $error("payload result outside payload phase");

  // An error result stops the parser
  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_ERROR) |=> (phase_q == PH_STOPPED))
    else $error("parser kept running after an error");

  // Payload phase always has bytes left to deliver
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != '0 && rem_q <= acc_q))
    else $error("payload count out of range");

  // Position never runs past the largest buffer
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= 32'(MAX_BUFFER_BYTES))
    else $error("byte position past largest buffer");

endmodule

// File: src/tlvd_skid.sv
// Output register with one skid entry for the TLV deframer results.
`timescale 1ns / 1ps
module tlvd_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  tlvd_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tlvd_pkg::result_t out_o
);
  import tlvd_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    out_take;

  assign out_take = out_valid_q && !out_stall_i;

  // Track which stages hold a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Move payloads: skid drains first, new results fill whichever stage is free
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The skid entry is only used behind a held output request
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output request");

  // No result arrives while the skid entry is occupied
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid_i)
    else $error("result lost on full skid");

endmodule
